/* rtl/core/assert_macros.svh */
// Assertion macros shared by the interpolator RTL.
// Plain SystemVerilog text; no other file is needed.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is high.
`define PLI_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define PLI_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/pli_pkg.sv */
// Package for the piecewise-linear interpolator: sizes, codes and the
// structs passed between the sequencer and the arithmetic unit.
// Depends on nothing.
`default_nettype none

package pli_pkg;

  // Table size and index widths.
  localparam int MAX_POINTS = 16;
  localparam int PTR_W      = $clog2(MAX_POINTS);
  localparam int N_W        = 5;

  // Stream and register port widths.
  localparam int S_DATA_W = 72;
  localparam int M_DATA_W = 40;
  localparam int ADDR_W   = 3;

  // Request kinds carried on s_tuser.
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Register indexes, taken from paddr[2].
  localparam logic REG_POINTS = 1'b0;
  localparam logic REG_EXTRAP = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_ZERO_WIDTH = 2'd1;
  localparam logic [1:0] STATUS_SATURATED  = 2'd2;
  localparam logic [1:0] STATUS_UNUSED     = 2'd3;

  // Bounds of the 32-bit signed result.
  localparam logic signed [31:0] RES_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] RES_MIN = 32'sh8000_0000;

  // Operands handed to the arithmetic unit.
  typedef struct packed {
    logic [31:0]        mag_dy;
    logic [31:0]        mag_dq;
    logic [31:0]        mag_dx;
    logic               neg;
    logic signed [31:0] y_left;
  } arith_req_t;

  // Finished result from the arithmetic unit.
  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
  } arith_res_t;

endpackage

`default_nettype wire

/* rtl/core/pli_arith.sv */
// Arithmetic unit of the interpolator: one 32x32 multiply, an overflow
// check and a bit-serial divide, then the saturating add. Uses pli_pkg.
`default_nettype none

module pli_arith
  import pli_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire arith_req_t req,
  output logic            busy,
  output logic            done,
  output arith_res_t      res
);

  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    A_IDLE,
    A_MUL,
    A_CHK,
    A_DIV,
    A_FIN
  } astate_t;

  astate_t            state;
  arith_req_t         op;
  logic [63:0]        prod;
  logic [31:0]        rem;
  logic [32:0]        dvd;
  logic [32:0]        quo;
  logic [5:0]         cnt;
  logic               sat;

  logic [32:0]        trial;
  logic               trial_ge;
  logic signed [34:0] sum;

  // One restoring-division step and the final signed sum.
  always_comb begin
    trial    = {rem, dvd[32]};
    trial_ge = (trial >= {1'b0, op.mag_dx});
    if (op.neg) begin
      sum = 35'(op.y_left) - $signed({2'b00, quo});
    end else begin
      sum = 35'(op.y_left) + $signed({2'b00, quo});
    end
  end

  assign busy = (state != A_IDLE);

  // Sequencer with its datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        A_IDLE: begin
          if (start) begin
            op    <= req;
            state <= A_MUL;
          end
        end
        A_MUL: begin
          prod  <= op.mag_dy * op.mag_dq;
          state <= A_CHK;
        end
        A_CHK: begin
          // The quotient fits 33 bits only if prod < dx * 2^33.
          sat <= ({1'b0, prod} >= {op.mag_dx, 33'd0});
          rem <= {1'b0, prod[63:33]};
          dvd <= prod[32:0];
          quo <= '0;
          cnt <= 6'd32;
          if ({1'b0, prod} >= {op.mag_dx, 33'd0}) begin
            state <= A_FIN;
          end else begin
            state <= A_DIV;
          end
        end
        A_DIV: begin
          if (trial_ge) begin
            rem <= 32'(trial - {1'b0, op.mag_dx});
          end else begin
            rem <= trial[31:0];
          end
          quo <= {quo[31:0], trial_ge};
          dvd <= {dvd[31:0], 1'b0};
          cnt <= cnt - 6'd1;
          if (cnt == 6'd0) begin
            state <= A_FIN;
          end
        end
        A_FIN: begin
          done <= 1'b1;
          if (sat) begin
            res.value  <= op.neg ? RES_MIN : RES_MAX;
            res.status <= STATUS_SATURATED;
          end else if (sum > 35'(RES_MAX)) begin
            res.value  <= RES_MAX;
            res.status <= STATUS_SATURATED;
          end else if (sum < 35'(RES_MIN)) begin
            res.value  <= RES_MIN;
            res.status <= STATUS_SATURATED;
          end else begin
            res.value  <= sum[31:0];
            res.status <= STATUS_OK;
          end
          state <= A_IDLE;
        end
        default: begin
          state <= A_IDLE;
        end
      endcase
    end
  end

  // Checks on the unit's own sequencing and saturation.
  `PLI_ASSERT(a_done_pulse, clk, rst, done |=> !done, "done held for more than one cycle")
  `PLI_ASSERT(a_start_idle, clk, rst, start |-> (state == A_IDLE), "start while busy")
  `PLI_ASSERT(a_sat_bound, clk, rst, (done && res.status == STATUS_SATURATED) |-> (res.value == RES_MAX || res.value == RES_MIN), "saturated value not at a bound")

endmodule

`default_nettype wire

/* rtl/core/piecewise_linear_interpolator_core.sv */
// Top level of the piecewise-linear interpolator: breakpoint memories,
// interval search sequencer, register port and output stage.
// Depends on pli_pkg and pli_arith.
//
// Requests arrive on the s_ stream. s_tuser selects a load (write one
// breakpoint x, y at point_index) or a query (interpolate at x_value).
// Each query yields one result on the m_ stream; loads yield none.
// A load is written as it is accepted. A query reads the start of the
// last segment, then takes k interval search steps, each one read of the
// x memory, with k from 0 to points_in_use - 2 (count limited to 2..16),
// then fetches both interval ends, clamps and prepares operands. The
// arithmetic unit then multiplies, checks the range, forms 33 quotient
// bits at one per cycle (skipped on overflow) and hands back the sum.
// A zero-width interval skips the arithmetic unit. One request is in
// work at a time; s_tready is high while idle. The result sits in an
// output register, so the next request is taken while a result still
// waits; a finished query stalls only while that register is still full
// and m_tready is low. Reset restores points_in_use = 2, no extrapolation
// and drops any request in work; the table is undefined until loaded.
// The user writes registers only while the block is idle; not enforced.
`default_nettype none

module piecewise_linear_interpolator_core
  import pli_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  // Request stream.
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  // [3:0] point_index, [35:4] x_value, [67:36] y_value, [71:68] zero
  input  wire logic [S_DATA_W-1:0] s_tdata,
  // [0] req_type
  input  wire logic                s_tuser,
  // Result stream.
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  // [31:0] result_value, [33:32] status, [39:34] zero
  output logic [M_DATA_W-1:0]      m_tdata,
  // Register port.
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ADDR_W-1:0]   paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  `include "assert_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE,
    S_END,
    S_WALK,
    S_FETCH_L,
    S_FETCH_R,
    S_CLAMP,
    S_PREP,
    S_WAIT,
    S_EMIT
  } state_t;

  // Breakpoint memories.
  logic [31:0] mem_x [MAX_POINTS];
  logic [31:0] mem_y [MAX_POINTS];
  logic [PTR_W-1:0]   rd_addr;
  logic signed [31:0] rd_x;
  logic signed [31:0] rd_y;
  logic               wr_en;

  // Registers.
  logic [N_W-1:0] points_in_use;
  logic           extrapolate_enable;

  // Sequencer state and working registers.
  state_t             state;
  logic [PTR_W-1:0]   n_last;
  logic [PTR_W-1:0]   l;
  logic signed [31:0] qx;
  logic signed [31:0] xl;
  logic signed [31:0] yl;
  logic signed [31:0] yr;
  logic signed [32:0] dx;
  logic signed [32:0] dq;
  arith_res_t         pending;

  // Request fields.
  logic [PTR_W-1:0]   in_index;
  logic signed [31:0] in_x;
  logic signed [31:0] in_y;
  logic               accept;

  // Combinational helpers.
  logic [PTR_W-1:0]   n_last_cfg;
  logic [PTR_W-1:0]   l_inc;
  logic signed [31:0] yr_c;
  logic signed [31:0] yl_c;
  logic signed [32:0] dy;
  logic               arith_start;
  arith_req_t         arith_req;
  logic               arith_busy;
  logic               arith_done;
  arith_res_t         arith_res;
  logic               cfg_write;

  function automatic logic [31:0] mag33(input logic signed [32:0] v);
    logic signed [32:0] n;
    n = -v;
    return v[32] ? n[31:0] : v[31:0];
  endfunction

  assign in_index = s_tdata[PTR_W-1:0];
  assign in_x     = s_tdata[35:4];
  assign in_y     = s_tdata[67:36];
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign wr_en    = accept && (s_tuser == REQ_LOAD);
  assign l_inc    = l + PTR_W'(1);

  // Breakpoint count limited to the table, as index of the last segment.
  always_comb begin
    if (points_in_use < N_W'(2)) begin
      n_last_cfg = '0;
    end else if (points_in_use > N_W'(MAX_POINTS)) begin
      n_last_cfg = PTR_W'(MAX_POINTS - 2);
    end else begin
      n_last_cfg = PTR_W'(points_in_use - N_W'(2));
    end
  end

  // Read address for the next memory access.
  always_comb begin
    case (state)
      S_IDLE:    rd_addr = n_last_cfg;
      S_END:     rd_addr = PTR_W'(1);
      S_WALK:    rd_addr = l + PTR_W'(2);
      S_FETCH_L: rd_addr = l;
      S_FETCH_R: rd_addr = l_inc;
      default:   rd_addr = l;
    endcase
  end

  // Memories: one write port for loads, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[in_index] <= in_x;
      mem_y[in_index] <= in_y;
    end
    rd_x <= mem_x[rd_addr];
    rd_y <= mem_y[rd_addr];
  end

  // End-point clamping when extrapolation is off.
  always_comb begin
    yr_c = rd_y;
    yl_c = yl;
    if (!extrapolate_enable) begin
      if (qx < xl) begin
        yr_c = yl;
      end
      if (qx > rd_x) begin
        yl_c = yr_c;
      end
    end
  end

  // Operands for the arithmetic unit.
  always_comb begin
    dy                 = 33'(yr) - 33'(yl);
    arith_req.mag_dy   = mag33(dy);
    arith_req.mag_dq   = mag33(dq);
    arith_req.mag_dx   = mag33(dx);
    arith_req.neg      = dy[32] ^ dq[32] ^ dx[32];
    arith_req.y_left   = yl;
    arith_start        = (state == S_PREP) && (dx != 33'sd0);
  end

  pli_arith u_arith (
    .clk   (clk),
    .rst   (rst),
    .start (arith_start),
    .req   (arith_req),
    .busy  (arith_busy),
    .done  (arith_done),
    .res   (arith_res)
  );

  // Search sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // The output register empties on a handshake unless a new result
      // replaces it in the same cycle.
      if (m_tvalid && m_tready && state != S_EMIT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && s_tuser == REQ_QUERY) begin
            qx     <= in_x;
            n_last <= n_last_cfg;
            state  <= S_END;
          end
        end
        S_END: begin
          // Past the start of the last segment, or walk from the first.
          if (qx >= rd_x) begin
            l     <= n_last;
            state <= S_FETCH_L;
          end else begin
            l <= '0;
            if (n_last == '0) begin
              state <= S_FETCH_L;
            end else begin
              state <= S_WALK;
            end
          end
        end
        S_WALK: begin
          if (qx > rd_x) begin
            l <= l_inc;
            if (l_inc >= n_last) begin
              state <= S_FETCH_L;
            end
          end else begin
            state <= S_FETCH_L;
          end
        end
        S_FETCH_L: begin
          state <= S_FETCH_R;
        end
        S_FETCH_R: begin
          xl    <= rd_x;
          yl    <= rd_y;
          state <= S_CLAMP;
        end
        S_CLAMP: begin
          yl    <= yl_c;
          yr    <= yr_c;
          dx    <= 33'(rd_x) - 33'(xl);
          dq    <= 33'(qx) - 33'(xl);
          state <= S_PREP;
        end
        S_PREP: begin
          if (dx == 33'sd0) begin
            pending.value  <= yl;
            pending.status <= STATUS_ZERO_WIDTH;
            state          <= S_EMIT;
          end else begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (arith_done) begin
            pending <= arith_res;
            state   <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {6'd0, pending.status, pending.value};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Register port: writes in the access phase, reads by address.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      points_in_use      <= N_W'(2);
      extrapolate_enable <= 1'b0;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_POINTS: points_in_use      <= pwdata[N_W-1:0];
        REG_EXTRAP: extrapolate_enable <= pwdata[0];
        default:    points_in_use      <= points_in_use;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_POINTS: prdata = {{(32 - N_W){1'b0}}, points_in_use};
      REG_EXTRAP: prdata = {31'd0, extrapolate_enable};
      default:    prdata = '0;
    endcase
  end

  // Checks on sequencing between the search and the arithmetic unit.
  `PLI_ASSERT(a_idle_unit_free, clk, rst, s_tready |-> !arith_busy, "arithmetic unit busy while idle")
  `PLI_ASSERT(a_walk_bound, clk, rst, (state == S_WALK) |-> (l < n_last), "search walked past the last segment")
  `PLI_ASSERT(a_done_when_waiting, clk, rst, arith_done |-> (state == S_WAIT), "arithmetic result with nobody waiting")
  `PLI_ASSERT(a_status_code, clk, rst, m_tvalid |-> (m_tdata[33:32] != STATUS_UNUSED), "undefined status code on output")

endmodule

`default_nettype wire

/* tb/piecewise_linear_interpolator_core_test.sv */
// Self-checking testbench for the piecewise-linear interpolator core: loads
// breakpoint tables, queries them under several register settings and checks
// every result against a predictor. Depends on pli_pkg and the core RTL only.
`default_nettype none

module piecewise_linear_interpolator_core_test
  import pli_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 80;
  localparam int HOLDOFF_CYCLES = 500;
  localparam int PHASE_REQUESTS = 40;
  localparam int NUM_PHASES = 8;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;
  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
  } interp_result_t;

  // Predicts interpolation results from its own copy of the table and the
  // registers, and matches them against what the core returns.
  class interp_scoreboard;
    logic signed [31:0] bp_x [MAX_POINTS];
    logic signed [31:0] bp_y [MAX_POINTS];
    logic [4:0]         points_reg;
    logic               extrap_reg;
    interp_result_t     expected_q [$];
    int                 errors;

    function new();
      points_reg = 5'd2;
      extrap_reg = 1'b0;
      errors = 0;
    endfunction

    function void set_register(logic idx, logic [31:0] value);
      if (idx == REG_POINTS) begin
        points_reg = value[4:0];
      end else begin
        extrap_reg = value[0];
      end
    endfunction

    // Counts outside the legal range act as the nearest bound.
    function int effective_count();
      if (points_reg < 2) return 2;
      if (points_reg > MAX_POINTS) return MAX_POINTS;
      return int'(points_reg);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function longint unsigned magnitude(longint v);
      return (v < 0) ? longint'(-v) : v;
    endfunction

    // Loads update the table; queries push the value they should produce.
    function void note_request(logic kind, logic [3:0] idx, logic signed [31:0] xv,
                               logic signed [31:0] yv);
      int                n;
      int                seg;
      longint            xq, xl, xr, yl, yr, dx, dy, dq, sum;
      longint unsigned   quot;
      logic              neg;
      interp_result_t    res;
      if (kind == REQ_LOAD) begin
        bp_x[idx] = xv;
        bp_y[idx] = yv;
        return;
      end
      n = effective_count();
      xq = longint'(xv);
      // Last segment at or beyond the second-to-last point, else walk up.
      seg = 0;
      if (xq >= longint'(bp_x[n-2])) begin
        seg = n - 2;
      end else begin
        while (seg < n - 2 && xq > longint'(bp_x[seg+1])) seg++;
      end
      xl = longint'(bp_x[seg]);
      yl = longint'(bp_y[seg]);
      xr = longint'(bp_x[seg+1]);
      yr = longint'(bp_y[seg+1]);
      // Without extrapolation, points outside the interval clamp to its ends.
      if (!extrap_reg) begin
        if (xq < xl) yr = yl;
        if (xq > xr) yl = yr;
      end
      dx = xr - xl;
      if (dx == 0) begin
        res.value = yl[31:0];
        res.status = STATUS_ZERO_WIDTH;
        expected_q.push_back(res);
        return;
      end
      dy = yr - yl;
      dq = xq - xl;
      neg = ((dy < 0) != (dq < 0)) != (dx < 0);
      quot = (magnitude(dy) * magnitude(dq)) / magnitude(dx);
      if (quot == 0) neg = 1'b0;
      res.status = STATUS_OK;
      if (quot > 64'h1_FFFF_FFFF) begin
        res.value = neg ? Q_MIN : Q_MAX;
        res.status = STATUS_SATURATED;
      end else begin
        sum = neg ? yl - longint'(quot) : yl + longint'(quot);
        if (sum > longint'(RES_MAX)) begin
          sum = longint'(RES_MAX);
          res.status = STATUS_SATURATED;
        end else if (sum < longint'(RES_MIN)) begin
          sum = longint'(RES_MIN);
          res.status = STATUS_SATURATED;
        end
        res.value = sum[31:0];
      end
      expected_q.push_back(res);
    endfunction

    function void check_result(logic [31:0] value, logic [1:0] status);
      interp_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result with no query pending: value %h status %0d",
                 $time, value, status);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (value !== want.value) begin
        $display("%0t: result_value mismatch: expected %h actual %h",
                 $time, want.value, value);
        errors++;
      end
      if (status !== want.status) begin
        $display("%0t: status mismatch: expected %0d actual %0d",
                 $time, want.status, status);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  // [3:0] point_index, [35:4] x_value, [67:36] y_value, [71:68] zero
  logic [S_DATA_W-1:0] s_tdata;
  // [0] req_type
  logic                s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  // [31:0] result_value, [33:32] status, [39:34] zero
  logic [M_DATA_W-1:0] m_tdata;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  interp_scoreboard sb = new();
  int  requests_sent = 0;
  int  results_seen = 0;
  int  burst_left = 0;
  bit  steady_sender = 0;
  int  cycles = 0;

  piecewise_linear_interpolator_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // 20 ns clock.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Run limit.
  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("piecewise_linear_interpolator_core test failed");
        $finish;
      end
    end
  end

  // Result side: check every accepted result, stall in random modes, and
  // twice hold off for a long stretch so the core backs up into its input.
  initial begin
    int mode;
    int mode_left;
    int holdoff_left;
    int next_holdoff;
    mode = 0;
    mode_left = 0;
    holdoff_left = 0;
    next_holdoff = 40;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        sb.check_result(m_tdata[31:0], m_tdata[33:32]);
        results_seen++;
        if (results_seen == next_holdoff && next_holdoff < 200) begin
          holdoff_left = HOLDOFF_CYCLES;
          next_holdoff += 110;
        end
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      if (holdoff_left > 0) begin
        holdoff_left--;
        m_tready <= 1'b0;
      end else begin
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= $urandom_range(0, 1);
          default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Offer one request in bursts with random gaps; returns at acceptance.
  task automatic send_request(input logic kind, input logic [3:0] idx,
                              input logic [31:0] xv, input logic [31:0] yv);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (steady_sender || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {4'b0, yv, xv, idx};
    do @(posedge clk); while (!s_tready);
    sb.note_request(kind, idx, xv, yv);
    requests_sent++;
  endtask

  // Stop offering and let every outstanding query finish.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the register takes the value at the
  // end of the access cycle. The bus then goes idle before the next write.
  task automatic write_register(input logic idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_register(idx, value);
    @(posedge clk);
  endtask

  // Strictly increasing x over the points in use, loaded in shuffled order.
  // Now and then one step is zero to form a zero-width interval.
  task automatic load_sorted_table();
    int          n, i, j, t, dup;
    int          order [MAX_POINTS];
    longint      smax, xcur, ybase, yslope;
    logic [31:0] xs [MAX_POINTS];
    logic [31:0] ys [MAX_POINTS];
    logic [31:0] picks [5];
    n = sb.effective_count();
    case ($urandom_range(0, 3))
      0: smax = 16;
      1: smax = 64'd1 << 16;
      2: smax = 64'd1 << 24;
      default: smax = 64'd1 << 27;
    endcase
    xcur = -64'sd2147483648 + (longint'($urandom) % (64'h1_0000_0000 - 16 * smax));
    dup = -1;
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 2))
        0: dup = 1;
        1: dup = n - 1;
        default: dup = $urandom_range(1, n - 1);
      endcase
    end
    ybase = longint'(signed'($urandom));
    yslope = longint'($urandom_range(0, 1 << 20)) - (1 << 19);
    picks = '{Q_MIN, Q_MAX, 32'h0, 32'hFFFF_FFFF, 32'h0001_0000};
    for (i = 0; i < n; i++) begin
      if (i > 0 && i != dup) xcur += longint'($urandom_range(1, int'(smax)));
      xs[i] = xcur[31:0];
      case ($urandom_range(0, 3))
        0: ys[i] = $urandom;
        1: ys[i] = 32'(ybase + yslope * i);
        2: ys[i] = picks[$urandom_range(0, 4)];
        default: ys[i] = 32'(ybase + longint'($urandom_range(0, 8191)) - 4096);
      endcase
      order[i] = i;
    end
    for (i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (i = 0; i < n; i++) begin
      send_request(REQ_LOAD, 4'(order[i]), xs[order[i]], ys[order[i]]);
    end
  endtask

  // Query points near the current table: at, around and between breakpoints,
  // beyond the ends, at the extremes, or anywhere.
  function automatic logic [31:0] pick_query_x();
    int     n, k;
    longint xl, xr, off, tmp;
    n = sb.effective_count();
    k = $urandom_range(0, n - 2);
    xl = longint'(sb.bp_x[k]);
    xr = longint'(sb.bp_x[k+1]);
    off = longint'($urandom_range(1, 1 << $urandom_range(0, 30)));
    case ($urandom_range(0, 7))
      0: tmp = longint'($urandom);
      1: tmp = $urandom_range(0, 1) ? longint'(signed'(Q_MIN)) : longint'(Q_MAX);
      2, 3: tmp = longint'(sb.bp_x[$urandom_range(0, n - 1)]);
      4: tmp = xl + longint'($urandom_range(0, 64)) - 32;
      5, 6: tmp = xl + ((xr - xl) * longint'($urandom_range(0, 1024))) / 1024;
      default: begin
        tmp = $urandom_range(0, 1) ? longint'(sb.bp_x[0]) - off
                                   : longint'(sb.bp_x[n-1]) + off;
      end
    endcase
    return tmp[31:0];
  endfunction

  // Mostly sorted tables followed by queries; some unsorted tables, stray
  // loads and bare queries mixed in.
  task automatic run_random_phase(input int target);
    int stop, pick, count, i;
    stop = requests_sent + target;
    while (requests_sent < stop) begin
      pick = $urandom_range(0, 19);
      if (pick < 13) begin
        load_sorted_table();
        count = $urandom_range(4, 14);
      end else if (pick < 15) begin
        for (i = 0; i < sb.effective_count(); i++) begin
          send_request(REQ_LOAD, 4'(i), $urandom, $urandom);
        end
        count = $urandom_range(3, 8);
      end else if (pick < 17) begin
        repeat ($urandom_range(1, 3)) send_request(REQ_LOAD, 4'($urandom), $urandom, $urandom);
        count = $urandom_range(2, 5);
      end else begin
        count = $urandom_range(3, 10);
      end
      repeat (count) send_request(REQ_QUERY, 4'($urandom), pick_query_x(), $urandom);
    end
  endtask

  initial begin
    int          i, phase;
    logic [31:0] x_init, y_init;
    int          phase_points [NUM_PHASES];
    logic        phase_extrap [NUM_PHASES];
    phase_points = '{2, 16, 0, 31, 1, 17, 5, 9};
    phase_extrap = '{0, 1, 1, 0, 1, 0, 1, 0};
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= REQ_LOAD;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: x steps of 2^27 from -2^30, entries 8 and 9 share x = 0,
    // y holds both extremes at the low end and the minimum at the top.
    for (i = 0; i < MAX_POINTS; i++) begin
      x_init = (i == 9) ? 32'h0 : 32'((i - 8) * (1 << 27));
      if (i == 0 || i == 15) y_init = Q_MIN;
      else if (i == 1) y_init = Q_MAX;
      else y_init = 32'(i * 32'h0111_1111 - 32'h0800_0000);
      send_request(REQ_LOAD, 4'(i), x_init, y_init);
    end
    // Reset settings: two points, clamping below, above and between.
    send_request(REQ_QUERY, 4'h0, Q_MIN, 32'h0);
    send_request(REQ_QUERY, 4'hF, Q_MAX, 32'hFFFF_FFFF);
    send_request(REQ_QUERY, 4'h5, 32'(-15 * (1 << 26)), 32'h0);
    wait_idle();
    // Whole table with extrapolation: saturation at both ends, an exact hit.
    write_register(REG_POINTS, 32'd16);
    write_register(REG_EXTRAP, 32'd1);
    send_request(REQ_QUERY, 4'h0, Q_MIN, 32'h0);
    send_request(REQ_QUERY, 4'h0, Q_MAX, 32'h0);
    send_request(REQ_QUERY, 4'h0, 32'h0, 32'h0);
    send_request(REQ_QUERY, 4'h0, 32'h0400_0000, 32'h0);
    wait_idle();
    // Ten points puts the shared x on the last segment: zero-width interval.
    write_register(REG_POINTS, 32'd10);
    send_request(REQ_QUERY, 4'h0, 32'h0010_0000, 32'h0);
    wait_idle();
    write_register(REG_EXTRAP, 32'd0);
    send_request(REQ_QUERY, 4'h0, 32'h0010_0000, 32'h0);
    wait_idle();

    // Random phases under a spread of settings, extremes included.
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase == NUM_PHASES - 1) begin
        phase_points[phase] = $urandom_range(0, 31);
        phase_extrap[phase] = $urandom_range(0, 1);
      end
      write_register(REG_POINTS,
                     {27'($urandom_range(0, 1 << 26)), 5'(phase_points[phase])});
      write_register(REG_EXTRAP,
                     {31'($urandom_range(0, 1 << 30)), phase_extrap[phase]});
      steady_sender = ($urandom_range(0, 3) == 0);
      run_random_phase(PHASE_REQUESTS);
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("piecewise_linear_interpolator_core test passed");
    end else begin
      $display("piecewise_linear_interpolator_core test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* piecewise_linear_interpolator_core.f */
+incdir+rtl/core
rtl/core/pli_pkg.sv
rtl/core/pli_arith.sv
rtl/core/piecewise_linear_interpolator_core.sv
tb/piecewise_linear_interpolator_core_test.sv
